### hw/rtl/sao_pkg.sv
// ----------------------------------------------------------------------------
// sao_pkg
// Types, constants and helpers shared by the straight-alpha source-over
// blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sao_pkg;

  localparam int CH_W      = 8;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // numerator of the channel divide: s*sa + d*da*inv/255 stays below 2^17
  localparam int NUM_W     = 17;
  // quotient of the channel divide is at most 509
  localparam int QUO_W     = 9;
  // restoring steps per divider stage
  localparam int DIV_STEPS = 3;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  typedef struct packed {
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_alpha;
    logic [CH_W-1:0] dst_blue;
    logic [CH_W-1:0] dst_green;
    logic [CH_W-1:0] dst_red;
    logic [CH_W-1:0] dst_alpha;
  } in_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_alpha;
  } out_pix_t;

  typedef enum logic [1:0] {
    MODE_BLEND = 2'b00,
    MODE_DST   = 2'b01,
    MODE_SRC   = 2'b10
  } mode_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } ch_div_t;

  typedef struct packed {
    ch_div_t         blue;
    ch_div_t         green;
    ch_div_t         red;
    logic [CH_W-1:0] ra;
    mode_t           mode;
    out_pix_t        byp;
  } div_item_t;

  // Floor divide by 255 for values below 255*2^16: estimate with x*257 >> 16,
  // which is low by at most one, then correct once.
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [31:0] prod;
    logic [15:0] q0;
    logic [24:0] back;
    logic [24:0] rem;
    prod = {x, 8'd0} + {8'd0, x};
    q0   = prod[31:16];
    back = {1'b0, q0, 8'd0} - {9'd0, q0};
    rem  = {1'b0, x} - back;
    if (rem >= 25'd255) begin
      return q0 + 16'd1;
    end
    return q0;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sao_front.sv
// ----------------------------------------------------------------------------
// sao_front
// Multiply and divide-by-255 stages: builds the output alpha and the three
// channel numerators, and sorts each pixel into its blend mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sao_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire sao_pkg::in_pix_t   in_pix,
  output logic                    out_vld,
  output sao_pkg::div_item_t      out_item
);

  localparam int NW = sao_pkg::NUM_W;

  // stage 1: products
  logic                 s1_vld_r;
  logic [15:0]          s1_ss_b_r, s1_ss_g_r, s1_ss_r_r;
  logic [15:0]          s1_dd_b_r, s1_dd_g_r, s1_dd_r_r;
  logic [15:0]          s1_t_r;
  logic [7:0]           s1_inv_r;
  logic [7:0]           s1_sa_r;
  sao_pkg::mode_t       s1_mode_r;
  sao_pkg::out_pix_t    s1_byp_r;
  sao_pkg::mode_t       s1_mode_nxt;
  sao_pkg::out_pix_t    s1_byp_nxt;
  logic [7:0]           inv_nxt;

  // stage 2: second product and output alpha
  logic                 s2_vld_r;
  logic [15:0]          s2_ss_b_r, s2_ss_g_r, s2_ss_r_r;
  logic [23:0]          s2_ddi_b_r, s2_ddi_g_r, s2_ddi_r_r;
  logic [7:0]           s2_ra_r;
  sao_pkg::mode_t       s2_mode_r;
  sao_pkg::out_pix_t    s2_byp_r;
  logic [15:0]          t_div;
  logic [8:0]           ra_sum;

  // stage 3: numerators
  logic                 s3_vld_r;
  sao_pkg::div_item_t   s3_item_r;
  sao_pkg::div_item_t   s3_item_nxt;

  always_comb begin
    inv_nxt = sao_pkg::CH_MAX - in_pix.src_alpha;
    if (in_pix.src_alpha == 8'd0) begin
      s1_mode_nxt = sao_pkg::MODE_DST;
      s1_byp_nxt  = '{out_blue:  in_pix.dst_blue,  out_green: in_pix.dst_green,
                      out_red:   in_pix.dst_red,   out_alpha: in_pix.dst_alpha};
    end else if (in_pix.src_alpha == sao_pkg::CH_MAX || in_pix.dst_alpha == 8'd0) begin
      s1_mode_nxt = sao_pkg::MODE_SRC;
      s1_byp_nxt  = '{out_blue:  in_pix.src_blue,  out_green: in_pix.src_green,
                      out_red:   in_pix.src_red,   out_alpha: in_pix.src_alpha};
    end else begin
      s1_mode_nxt = sao_pkg::MODE_BLEND;
      s1_byp_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ss_b_r <= 16'(in_pix.src_blue)  * 16'(in_pix.src_alpha);
    s1_ss_g_r <= 16'(in_pix.src_green) * 16'(in_pix.src_alpha);
    s1_ss_r_r <= 16'(in_pix.src_red)   * 16'(in_pix.src_alpha);
    s1_dd_b_r <= 16'(in_pix.dst_blue)  * 16'(in_pix.dst_alpha);
    s1_dd_g_r <= 16'(in_pix.dst_green) * 16'(in_pix.dst_alpha);
    s1_dd_r_r <= 16'(in_pix.dst_red)   * 16'(in_pix.dst_alpha);
    s1_t_r    <= 16'(in_pix.dst_alpha) * 16'(inv_nxt);
    s1_inv_r  <= inv_nxt;
    s1_sa_r   <= in_pix.src_alpha;
    s1_mode_r <= s1_mode_nxt;
    s1_byp_r  <= s1_byp_nxt;
  end

  // out alpha never exceeds 255, so the low byte of the sum is exact
  assign t_div  = sao_pkg::div255({8'd0, s1_t_r});
  assign ra_sum = {1'b0, s1_sa_r} + t_div[8:0];

  always_ff @(posedge clk) begin
    s2_ss_b_r  <= s1_ss_b_r;
    s2_ss_g_r  <= s1_ss_g_r;
    s2_ss_r_r  <= s1_ss_r_r;
    s2_ddi_b_r <= 24'(s1_dd_b_r) * 24'(s1_inv_r);
    s2_ddi_g_r <= 24'(s1_dd_g_r) * 24'(s1_inv_r);
    s2_ddi_r_r <= 24'(s1_dd_r_r) * 24'(s1_inv_r);
    s2_ra_r    <= ra_sum[7:0];
    s2_mode_r  <= s1_mode_r;
    s2_byp_r   <= s1_byp_r;
  end

  always_comb begin
    s3_item_nxt.blue.rem  = NW'(s2_ss_b_r) + NW'(sao_pkg::div255(s2_ddi_b_r));
    s3_item_nxt.green.rem = NW'(s2_ss_g_r) + NW'(sao_pkg::div255(s2_ddi_g_r));
    s3_item_nxt.red.rem   = NW'(s2_ss_r_r) + NW'(sao_pkg::div255(s2_ddi_r_r));
    s3_item_nxt.blue.quo  = '0;
    s3_item_nxt.green.quo = '0;
    s3_item_nxt.red.quo   = '0;
    s3_item_nxt.ra        = s2_ra_r;
    s3_item_nxt.mode      = s2_mode_r;
    s3_item_nxt.byp       = s2_byp_r;
  end

  always_ff @(posedge clk) begin
    s3_item_r <= s3_item_nxt;
  end

  assign out_vld  = s3_vld_r;
  assign out_item = s3_item_r;

endmodule

`default_nettype wire

### hw/rtl/sao_div_stage.sv
// ----------------------------------------------------------------------------
// sao_div_stage
// One registered slice of the restoring channel divider: a few quotient
// bits for each of the three colour channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sao_div_stage #(
  parameter int TOP_BIT = sao_pkg::QUO_W - 1,
  parameter int STEPS   = sao_pkg::DIV_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire sao_pkg::div_item_t in_item,
  output logic                    out_vld,
  output sao_pkg::div_item_t      out_item
);

  localparam int NW = sao_pkg::NUM_W;
  localparam int QW = sao_pkg::QUO_W;

  logic               vld_r;
  sao_pkg::div_item_t item_r;
  sao_pkg::div_item_t item_nxt;

  function automatic sao_pkg::ch_div_t step_ch(input sao_pkg::ch_div_t c,
                                               input logic [7:0] ra);
    sao_pkg::ch_div_t r;
    logic [NW-1:0]    trial;
    r = c;
    for (int k = 0; k < STEPS; k++) begin
      trial = NW'(ra) << (TOP_BIT - k);
      if (r.rem >= trial) begin
        r.rem = r.rem - trial;
        r.quo = {r.quo[QW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    item_nxt       = in_item;
    item_nxt.blue  = step_ch(in_item.blue,  in_item.ra);
    item_nxt.green = step_ch(in_item.green, in_item.ra);
    item_nxt.red   = step_ch(in_item.red,   in_item.ra);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

`default_nettype wire

### hw/rtl/straight_alpha_over_blend_top.sv
// ----------------------------------------------------------------------------
// straight_alpha_over_blend_top
// Source-over blend of a straight-alpha RGBA pixel onto a BGRA pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_pix and raise start; the item is taken at the
//   rising edge where start is high and busy is low. One item may be
//   offered on every cycle; busy only stands high while in reset and for
//   the first cycle after it.
//   Result channel: out_valid is high for exactly one cycle with out_pix,
//   after the item has passed the pipeline. Items leave in the order they
//   came in, one per cycle at full rate.
//   Pipeline: one stage of 8x8 products, one of the wider product and the
//   output alpha, one for the channel numerators, three divider stages of
//   three quotient bits each, and the output register with the bypass
//   select for the transparent and opaque cases. The divider sets the depth.
//   Reset: synchronous, active low; drops every item in flight.
//   The receiver cannot hold results off, so nothing ever stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module straight_alpha_over_blend_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sao_pkg::in_pix_t  in_pix,
  output logic                   out_valid,
  output sao_pkg::out_pix_t      out_pix
);

  localparam int NSTG = sao_pkg::DIV_STAGES;

  logic               busy_r;
  logic               busy_nxt;
  logic               acc;
  logic               out_valid_r;
  sao_pkg::out_pix_t  out_pix_r;
  sao_pkg::out_pix_t  out_pix_nxt;

  logic               dv   [NSTG+1];
  sao_pkg::div_item_t ditem[NSTG+1];

  // hold busy through reset, release it once reset has gone
  assign busy_nxt = 1'b0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end
  assign busy = busy_r;
  assign acc  = start && !busy_r;

  // products, output alpha and numerators
  sao_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc),
    .in_pix   (in_pix),
    .out_vld  (dv[0]),
    .out_item (ditem[0])
  );

  // restoring divider, most significant quotient bits first
  for (genvar g = 0; g < NSTG; g++) begin : g_div
    sao_div_stage #(
      .TOP_BIT (sao_pkg::QUO_W - 1 - g * sao_pkg::DIV_STEPS),
      .STEPS   (sao_pkg::DIV_STEPS)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv[g]),
      .in_item  (ditem[g]),
      .out_vld  (dv[g+1]),
      .out_item (ditem[g+1])
    );
  end

  // pick the blended pixel or the bypassed one; keep the low byte of each
  // quotient
  always_comb begin
    case (ditem[NSTG].mode)
      sao_pkg::MODE_BLEND: begin
        out_pix_nxt.out_blue  = ditem[NSTG].blue.quo[7:0];
        out_pix_nxt.out_green = ditem[NSTG].green.quo[7:0];
        out_pix_nxt.out_red   = ditem[NSTG].red.quo[7:0];
        out_pix_nxt.out_alpha = ditem[NSTG].ra;
      end
      sao_pkg::MODE_DST, sao_pkg::MODE_SRC: begin
        out_pix_nxt = ditem[NSTG].byp;
      end
      default: begin
        out_pix_nxt = ditem[NSTG].byp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule

`default_nettype wire

### hw/rtl/sao_checker.sv
// ----------------------------------------------------------------------------
// sao_checker
// Port-level checks on the blend block: latency, reset release, the output
// alpha floor and the transparent and opaque bypass paths.
// ----------------------------------------------------------------------------
`default_nettype none

module sao_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire sao_pkg::in_pix_t  in_pix,
  input wire logic              out_valid,
  input wire sao_pkg::out_pix_t out_pix
);

  logic acc;
  assign acc = start && !busy;

  // every result comes from a matching item taken on the input channel
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 7))
    else $error("result without a matching item");

  // busy drops once reset has been released
  a_busy_free: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // transparent source passes the destination through
  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(acc && in_pix.src_alpha == 8'd0, 7)) |->
      (out_pix.out_blue  == $past(in_pix.dst_blue, 7)  &&
       out_pix.out_green == $past(in_pix.dst_green, 7) &&
       out_pix.out_red   == $past(in_pix.dst_red, 7)   &&
       out_pix.out_alpha == $past(in_pix.dst_alpha, 7)))
    else $error("transparent source altered the destination");

  // opaque source replaces the destination
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(acc && in_pix.src_alpha == 8'd255, 7)) |->
      (out_pix.out_blue  == $past(in_pix.src_blue, 7)  &&
       out_pix.out_green == $past(in_pix.src_green, 7) &&
       out_pix.out_red   == $past(in_pix.src_red, 7)   &&
       out_pix.out_alpha == 8'd255))
    else $error("opaque source not copied");

  // coverage of the source never lowers the alpha below the source alpha
  a_alpha_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(acc && in_pix.src_alpha != 8'd0, 7)) |->
      (out_pix.out_alpha >= $past(in_pix.src_alpha, 7)))
    else $error("output alpha below source alpha");

endmodule

bind straight_alpha_over_blend_top sao_checker u_sao_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_pix    (in_pix),
  .out_valid (out_valid),
  .out_pix   (out_pix)
);

`default_nettype wire
